### hdl/assert_macros.svh
// Assertion macros shared by the rasterizer modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define BGR_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Condition must never be seen at a clock edge outside reset.
`define BGR_NEVER(lbl, clk, rstn, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);

`endif

### hdl/bgr_pkg.sv
// Types, constants and helper functions of the bitmap glyph rasterizer.
`timescale 1ns / 1ps

package bgr_pkg;

    // Default coordinate register width.
    localparam int COORD_BITS_DEF = 12;
    // Depth of the job queue between front and back.
    localparam int QUEUE_DEPTH = 4;

    // Supported font heights.
    localparam logic [7:0] FONT_12 = 8'd12;
    localparam logic [7:0] FONT_16 = 8'd16;
    localparam logic [7:0] FONT_24 = 8'd24;

    // Result status codes.
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_BAD_SIZE = 2'd1;
    localparam logic [1:0] ST_OFF_AREA = 2'd2;

    // Configuration register indexes.
    localparam logic [1:0] REG_DISP_WIDTH  = 2'd0;
    localparam logic [1:0] REG_DISP_HEIGHT = 2'd1;
    localparam logic [1:0] REG_INK_COLOR   = 2'd2;
    localparam logic [1:0] REG_PAPER_COLOR = 2'd3;

    // Configuration reset values.
    localparam logic [12:0] RST_DISP_WIDTH  = 13'd320;
    localparam logic [12:0] RST_DISP_HEIGHT = 13'd240;
    localparam logic [15:0] RST_INK_COLOR   = 16'h0000;
    localparam logic [15:0] RST_PAPER_COLOR = 16'hFFFF;

    // Input item.
    typedef struct packed {
        logic        first_byte;
        logic [11:0] start_x;
        logic [11:0] start_y;
        logic [7:0]  font_size;
        logic        transparent;
        logic [7:0]  glyph_byte;
    } t_in;

    // Result item.
    typedef struct packed {
        logic [11:0] point_x;
        logic [11:0] point_y;
        logic [15:0] pixel_color;
        logic        draws;
        logic [1:0]  status;
        logic        last_of_byte;
    } t_out;

    // Configuration register set.
    typedef struct packed {
        logic [12:0] disp_width;
        logic [12:0] disp_height;
        logic [15:0] ink_color;
        logic [15:0] paper_color;
    } t_cfg;

    // Classified byte held in the job queue.
    typedef struct packed {
        logic        first;
        logic        size_ok;
        logic [11:0] start_x;
        logic [11:0] start_y;
        logic [7:0]  height;
        logic        transparent;
        logic [7:0]  glyph;
        logic [5:0]  nbytes;
    } t_job;

    // True for the font heights the rasterizer handles.
    function automatic logic size_supported(input logic [7:0] size);
        return (size == FONT_12) || (size == FONT_16) || (size == FONT_24);
    endfunction

    // Bytes per glyph: ceil(size/8) * (size/2).
    function automatic logic [5:0] glyph_bytes(input logic [7:0] size);
        logic [5:0] n;
        n = 6'd0;
        if (size == FONT_12) begin
            n = 6'd12;
        end else if (size == FONT_16) begin
            n = 6'd16;
        end else if (size == FONT_24) begin
            n = 6'd36;
        end
        return n;
    endfunction

endpackage

### hdl/bgr_front.sv
// Front end: accepts input bytes and classifies them into queue jobs.
`timescale 1ns / 1ps

module bgr_front (
    input  logic          i_valid,
    output logic          o_ready,
    input  bgr_pkg::t_in  i_data,
    input  logic          i_full,
    output logic          o_push,
    output bgr_pkg::t_job o_job
);

    // Transfer whenever the queue has room.
    assign o_ready = !i_full;
    assign o_push  = i_valid && !i_full;

    // Decode the header fields of a first byte.
    always_comb begin
        o_job.first       = i_data.first_byte;
        o_job.size_ok     = bgr_pkg::size_supported(i_data.font_size);
        o_job.start_x     = i_data.start_x;
        o_job.start_y     = i_data.start_y;
        o_job.height      = i_data.font_size;
        o_job.transparent = i_data.transparent;
        o_job.glyph       = i_data.glyph_byte;
        o_job.nbytes      = bgr_pkg::glyph_bytes(i_data.font_size);
    end

endmodule

### hdl/bgr_queue.sv
// Small register FIFO that decouples the front end from the back end.
`timescale 1ns / 1ps

`include "assert_macros.svh"

module bgr_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNTW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
    localparam logic [CNTW-1:0] FULL_CNT = CNTW'(DEPTH);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wp;
    logic [AW-1:0]    r_rp;
    logic [CNTW-1:0]  r_cnt;

    assign o_full  = (r_cnt == FULL_CNT);
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rp];

    // Storage write.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == LAST_PTR) ? '0 : r_wp + AW'(1);
            end
            if (i_pop) begin
                r_rp <= (r_rp == LAST_PTR) ? '0 : r_rp + AW'(1);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + CNTW'(1);
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - CNTW'(1);
            end
        end
    end

    `BGR_NEVER(a_no_overflow, i_clk, i_rst_n, i_push && o_full && !i_pop, "queue overflow")
    `BGR_NEVER(a_no_underflow, i_clk, i_rst_n, i_pop && (r_cnt == '0), "queue underflow")

endmodule

### hdl/bgr_back.sv
// Back end: expands queued glyph bytes into pixel writes, one bit per cycle while the output does not stall.
`timescale 1ns / 1ps

`include "assert_macros.svh"

module bgr_back #(
    parameter int COORD_BITS = bgr_pkg::COORD_BITS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  bgr_pkg::t_cfg i_cfg,
    input  logic          i_job_valid,
    input  bgr_pkg::t_job i_job,
    output logic          o_job_pop,
    output logic          o_valid,
    input  logic          i_ready,
    output bgr_pkg::t_out o_data
);

    // Compare width: one carry bit over the coordinate, at least the limit width.
    localparam int CW = (COORD_BITS + 1 > 13) ? COORD_BITS + 1 : 13;

    // Character state.
    logic [COORD_BITS-1:0] r_cx, r_cy, r_top;
    logic [7:0]            r_h;
    logic                  r_opoff;
    logic [5:0]            r_left;
    logic                  r_aband;
    // Byte in progress.
    logic                  r_busy;
    logic [7:0]            r_bits;
    logic [2:0]            r_bidx;
    // Pending result, held until its last-of-byte flag is known.
    logic                  r_pv;
    logic                  r_pk;
    bgr_pkg::t_out         r_p;
    // Output register.
    logic                  r_ov;
    bgr_pkg::t_out         r_out;

    logic [COORD_BITS-1:0] n_cx, n_cy, n_top;
    logic [7:0]            n_h;
    logic                  n_opoff;
    logic [5:0]            n_left;
    logic                  n_aband;
    logic                  n_busy;
    logic [7:0]            n_bits;
    logic [2:0]            n_bidx;
    logic                  n_pv;
    logic                  n_pk;
    bgr_pkg::t_out         n_p;
    logic                  n_ov;
    bgr_pkg::t_out         n_out;

    logic                  go, take, load, bad, drop, step;
    logic [COORD_BITS-1:0] e_x, e_y, e_top;
    logic [7:0]            e_h;
    logic                  e_op;
    logic [5:0]            e_left, left_dec;
    logic [7:0]            bits;
    logic [2:0]            bidx;
    logic                  draw, row_fail, col_fail, fail, wrap, term;
    logic [CW-1:0]         ny_c, nx_c;
    logic [COORD_BITS-1:0] ny, row_off;
    logic                  e_valid;
    bgr_pkg::t_out         e_data;

    assign go        = !r_ov || i_ready;
    assign o_valid   = r_ov;
    assign o_data    = r_out;
    assign o_job_pop = go && take;

    // Classify the queue head and select the state the bit step works on.
    always_comb begin
        take = !r_busy && i_job_valid;
        bad  = take && i_job.first && !i_job.size_ok;
        load = take && i_job.first && i_job.size_ok;
        drop = take && !i_job.first && r_aband;
        step = r_busy || (take && !bad && !drop);

        e_x    = load ? COORD_BITS'(i_job.start_x) : r_cx;
        e_y    = load ? COORD_BITS'(i_job.start_y) : r_cy;
        e_top  = load ? COORD_BITS'(i_job.start_y) : r_top;
        e_h    = load ? i_job.height : r_h;
        e_op   = load ? i_job.transparent : r_opoff;
        e_left = load ? i_job.nbytes : r_left;
        bits   = r_busy ? r_bits : i_job.glyph;
        bidx   = r_busy ? r_bidx : 3'd0;
    end

    // One bit: pixel, row advance, column wrap and limit checks.
    always_comb begin
        draw     = bits[7] || !e_op;
        ny_c     = CW'(e_y) + CW'(1);
        row_fail = (ny_c >= CW'(i_cfg.disp_height));
        ny       = ny_c[COORD_BITS-1:0];
        row_off  = ny - e_top;
        wrap     = !row_fail && (row_off == COORD_BITS'(e_h));
        nx_c     = CW'(e_x) + CW'(1);
        col_fail = wrap && (nx_c >= CW'(i_cfg.disp_width));
        fail     = row_fail || col_fail;
        term     = fail || wrap || (bidx == 3'd7);
        left_dec = e_left - 6'd1;

        e_valid = bad || (step && (draw || fail));
        e_data  = '0;
        if (bad) begin
            e_data.status = bgr_pkg::ST_BAD_SIZE;
        end else if (draw) begin
            e_data.point_x     = 12'(e_x);
            e_data.point_y     = 12'(e_y);
            e_data.pixel_color = bits[7] ? i_cfg.ink_color : i_cfg.paper_color;
            e_data.draws       = 1'b1;
            e_data.status      = fail ? bgr_pkg::ST_OFF_AREA : bgr_pkg::ST_OK;
        end else begin
            e_data.status = bgr_pkg::ST_OFF_AREA;
        end
    end

    // Next state of the character, the byte walk and the result path.
    always_comb begin
        n_cx    = r_cx;
        n_cy    = r_cy;
        n_top   = r_top;
        n_h     = r_h;
        n_opoff = r_opoff;
        n_left  = r_left;
        n_aband = r_aband;
        n_busy  = r_busy;
        n_bits  = r_bits;
        n_bidx  = r_bidx;
        n_pv    = r_pv;
        n_pk    = r_pk;
        n_p     = r_p;
        n_ov    = 1'b0;
        n_out   = r_p;

        if (bad) begin
            n_aband = 1'b1;
        end
        if (step) begin
            n_top   = e_top;
            n_h     = e_h;
            n_opoff = e_op;
            n_left  = e_left;
            n_cx    = wrap ? nx_c[COORD_BITS-1:0] : e_x;
            n_cy    = wrap ? e_top : ny;
            if (load) begin
                n_aband = 1'b0;
            end
            if (fail) begin
                n_aband = 1'b1;
                n_busy  = 1'b0;
            end else if (term) begin
                n_busy = 1'b0;
                n_left = left_dec;
                if (left_dec == 6'd0) begin
                    n_aband = 1'b1;
                end
            end else begin
                n_busy = 1'b1;
                n_bits = {bits[6:0], 1'b0};
                n_bidx = bidx + 3'd1;
            end
        end

        // A new result pushes the pending one out; a byte end flushes it.
        if (e_valid) begin
            if (r_pv) begin
                n_ov = 1'b1;
                n_out.last_of_byte = r_pk;
            end
            n_pv = 1'b1;
            n_pk = bad || term;
            n_p  = e_data;
        end else if (r_pv && (r_pk || (step && term))) begin
            n_ov = 1'b1;
            n_out.last_of_byte = 1'b1;
            n_pv = 1'b0;
        end
    end

    // State and registered outputs; the whole back end holds while the output stalls.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cx    <= '0;
            r_cy    <= '0;
            r_top   <= '0;
            r_h     <= '0;
            r_opoff <= 1'b0;
            r_left  <= '0;
            r_aband <= 1'b1;
            r_busy  <= 1'b0;
            r_bits  <= '0;
            r_bidx  <= '0;
            r_pv    <= 1'b0;
            r_pk    <= 1'b0;
            r_ov    <= 1'b0;
        end else if (go) begin
            r_cx    <= n_cx;
            r_cy    <= n_cy;
            r_top   <= n_top;
            r_h     <= n_h;
            r_opoff <= n_opoff;
            r_left  <= n_left;
            r_aband <= n_aband;
            r_busy  <= n_busy;
            r_bits  <= n_bits;
            r_bidx  <= n_bidx;
            r_pv    <= n_pv;
            r_pk    <= n_pk;
            r_ov    <= n_ov;
        end
    end

    // Result payload registers.
    always_ff @(posedge i_clk) begin
        if (go) begin
            r_p   <= n_p;
            r_out <= n_out;
        end
    end

    `BGR_ASSERT(a_pend_open_byte, i_clk, i_rst_n, (r_pv && !r_pk) |-> r_busy,
        "pending result of unfinished byte with no byte in progress")
    `BGR_ASSERT(a_busy_active, i_clk, i_rst_n, r_busy |-> !r_aband,
        "byte in progress while no character is active")
    `BGR_ASSERT(a_stall_holds, i_clk, i_rst_n, (r_ov && !i_ready) |=> (r_busy == $past(r_busy)),
        "back end advanced while the output stalled")

endmodule

### hdl/bitmap_glyph_rasterizer.sv
// Top level of the column-major bitmap glyph rasterizer.
`timescale 1ns / 1ps

// Usage:
//   Input channel (i_valid / o_ready / i_data) carries glyph bytes in font
//   table order; the byte with first_byte set also gives the start corner,
//   the font height (12, 16 or 24) and the transparent flag.
//   Output channel (o_valid / i_ready / o_data) carries pixel writes and
//   status-only results; last_of_byte marks the final result of a byte.
//   Configuration: i_cfg_we writes i_cfg_data into register i_cfg_index
//   (0 width, 1 height, 2 ink color, 3 paper color); the user must write
//   only while the block is idle, which the block itself does not enforce.
// Throughput: the back end walks one bit per cycle while the output does
//   not stall, up to the column end of a byte; the expander is the pacing
//   unit, with one output transfer per cycle at best.
// Results: each result waits in a pending register until the next result
//   of its byte or the byte end, then moves to the output register.
// A four-entry queue lets input transfers continue while the back end works.
// Reset clears the queue and the output, loads the default configuration
//   and leaves no character active. When the receiver stalls the back end
//   holds; the queue keeps taking bytes until it is full.
module bitmap_glyph_rasterizer #(
    parameter int COORD_BITS  = bgr_pkg::COORD_BITS_DEF,
    parameter int QUEUE_DEPTH = bgr_pkg::QUEUE_DEPTH
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  bgr_pkg::t_in  i_data,
    output logic          o_valid,
    input  logic          i_ready,
    output bgr_pkg::t_out o_data,
    input  logic          i_cfg_we,
    input  logic [1:0]    i_cfg_index,
    input  logic [15:0]   i_cfg_data
);

    bgr_pkg::t_cfg r_cfg;
    bgr_pkg::t_job push_job;
    bgr_pkg::t_job head_job;
    logic          push, full, head_valid, pop;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.disp_width  <= bgr_pkg::RST_DISP_WIDTH;
            r_cfg.disp_height <= bgr_pkg::RST_DISP_HEIGHT;
            r_cfg.ink_color   <= bgr_pkg::RST_INK_COLOR;
            r_cfg.paper_color <= bgr_pkg::RST_PAPER_COLOR;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                bgr_pkg::REG_DISP_WIDTH:  r_cfg.disp_width  <= i_cfg_data[12:0];
                bgr_pkg::REG_DISP_HEIGHT: r_cfg.disp_height <= i_cfg_data[12:0];
                bgr_pkg::REG_INK_COLOR:   r_cfg.ink_color   <= i_cfg_data;
                bgr_pkg::REG_PAPER_COLOR: r_cfg.paper_color <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Front end: input transfer and classification.
    bgr_front u_front (
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_data  (i_data),
        .i_full  (full),
        .o_push  (push),
        .o_job   (push_job)
    );

    // Job queue.
    bgr_queue #(
        .WIDTH ($bits(bgr_pkg::t_job)),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_job),
        .o_full  (full),
        .i_pop   (pop),
        .o_valid (head_valid),
        .o_data  (head_job)
    );

    // Back end: bit walk and result output.
    bgr_back #(
        .COORD_BITS (COORD_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_job_valid (head_valid),
        .i_job       (head_job),
        .o_job_pop   (pop),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_data      (o_data)
    );

endmodule
